### rtl/core/i2c_master_transfer_sequencer_defines.svh
// ----------------------------------------------------------------------------
// i2c master transfer sequencer assertion macros
// shared concurrent assertion forms for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2C_MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2C_MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/i2c_mts_pkg.sv
// ----------------------------------------------------------------------------
// i2c_mts_pkg
// types and constants shared by the i2c master transfer sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2c_mts_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int MAX_LEN   = (BUF_DEPTH < 32) ? BUF_DEPTH : 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_SEND   = 3'd2,
    ACT_RESUME = 3'd3,
    ACT_STOP   = 3'd4
  } action_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [4:0]  buf_index;
    logic [7:0]  tx_value;
    logic [6:0]  device_addr;
    logic        is_read;
    logic [5:0]  msg_length;
    logic        bus_busy;
    logic        nack_seen;
    logic [7:0]  rx_data;
  } in_word_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  bus_byte;
    logic        ack_enable;
    logic        read_mode;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [4:0]  rx_index;
    logic        done_res;
    logic        error;
    logic        busy_res;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } txbuf_wr_t;

endpackage

`default_nettype wire

### rtl/core/i2c_mts_txbuf.sv
// ----------------------------------------------------------------------------
// i2c_mts_txbuf
// generic ram, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_mts_txbuf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/i2c_mts_ctrl.sv
// ----------------------------------------------------------------------------
// i2c_mts_ctrl
// message state and per-word decision logic of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_mts_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire i2c_mts_pkg::in_word_t          item_i,
  input  wire logic [7:0]                     rd_data_i,
  output i2c_mts_pkg::out_word_t              res_o,
  output i2c_mts_pkg::txbuf_wr_t              wr_o,
  output logic [i2c_mts_pkg::BUF_AW-1:0]      rd_addr_o
);

  logic [5:0] byte_count_q, byte_count_d;
  logic       active_q, active_d;
  logic       dir_read_q, dir_read_d;
  logic [5:0] length_q, length_d;
  logic       bypass_hit_q;
  logic [7:0] bypass_data_q;
  logic [7:0] rd_byte;

  i2c_mts_pkg::out_word_t res;
  i2c_mts_pkg::txbuf_wr_t wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      active_q     <= 1'b0;
      dir_read_q   <= 1'b0;
      length_q     <= '0;
    end else if (step_i) begin
      byte_count_q <= byte_count_d;
      active_q     <= active_d;
      dir_read_q   <= dir_read_d;
      length_q     <= length_d;
    end
  end

  // write data forwarded when the prefetched entry was written at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_hit_q  <= 1'b0;
      bypass_data_q <= '0;
    end else begin
      bypass_hit_q  <= wr.we && (wr.addr == rd_addr_o);
      bypass_data_q <= wr.data;
    end
  end

  // prefetch the entry for the count that the next word will see
  assign rd_addr_o = i2c_mts_pkg::BUF_AW'(step_i ? byte_count_d : byte_count_q);
  assign rd_byte   = bypass_hit_q ? bypass_data_q : rd_data_i;

  always_comb begin
    byte_count_d = byte_count_q;
    active_d     = active_q;
    dir_read_d   = dir_read_q;
    length_d     = length_q;
    res          = '0;
    res.action   = i2c_mts_pkg::ACT_NONE;
    wr.we        = 1'b0;
    wr.addr      = i2c_mts_pkg::BUF_AW'(item_i.buf_index);
    wr.data      = item_i.tx_value;

    case (item_i.cmd)
      i2c_mts_pkg::CMD_LOAD: begin
        wr.we = (32'(item_i.buf_index) < i2c_mts_pkg::BUF_DEPTH);
      end
      i2c_mts_pkg::CMD_START: begin
        if (active_q) begin
          res.error = 1'b1;
        end else if (item_i.bus_busy) begin
          res.error    = 1'b1;
          res.done_res = 1'b1;
        end else begin
          if (32'(item_i.msg_length) > i2c_mts_pkg::MAX_LEN) begin
            length_d = 6'(i2c_mts_pkg::MAX_LEN);
          end else begin
            length_d = item_i.msg_length;
          end
          dir_read_d     = item_i.is_read;
          byte_count_d   = '0;
          active_d       = 1'b1;
          res.action     = i2c_mts_pkg::ACT_START;
          res.bus_byte   = {item_i.device_addr, item_i.is_read};
          res.ack_enable = 1'b1;
          res.read_mode  = item_i.is_read;
        end
      end
      i2c_mts_pkg::CMD_EVENT: begin
        if (active_q) begin
          res.read_mode = dir_read_q;
          if (byte_count_q == '0 && item_i.nack_seen) begin
            active_d     = 1'b0;
            res.action   = i2c_mts_pkg::ACT_STOP;
            res.done_res = 1'b1;
            res.error    = 1'b1;
          end else begin
            byte_count_d = byte_count_q + 6'd1;
            if (!dir_read_q) begin
              if (byte_count_q < length_q &&
                  32'(byte_count_q) < i2c_mts_pkg::BUF_DEPTH) begin
                res.action   = i2c_mts_pkg::ACT_SEND;
                res.bus_byte = rd_byte;
              end else begin
                active_d     = 1'b0;
                res.action   = i2c_mts_pkg::ACT_STOP;
                res.done_res = 1'b1;
              end
            end else if (byte_count_q == '0) begin
              if (length_q == '0) begin
                active_d     = 1'b0;
                res.action   = i2c_mts_pkg::ACT_STOP;
                res.done_res = 1'b1;
              end else begin
                res.action     = i2c_mts_pkg::ACT_RESUME;
                res.ack_enable = (length_q > 6'd1);
              end
            end else begin
              res.rx_valid = 1'b1;
              res.rx_byte  = item_i.rx_data;
              res.rx_index = 5'(byte_count_q - 6'd1);
              if (byte_count_q < length_q) begin
                res.action     = i2c_mts_pkg::ACT_RESUME;
                res.ack_enable = (({1'b0, byte_count_q} + 7'd1) < {1'b0, length_q});
              end else begin
                active_d     = 1'b0;
                res.action   = i2c_mts_pkg::ACT_STOP;
                res.done_res = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.busy_res = active_d;
    wr.we        = wr.we & step_i;
  end

  assign res_o = res;
  assign wr_o  = wr;

  `I2C_MTS_ASSERT_NOW(a_count_in_range, clk_i, rst_ni, active_q, byte_count_q <= length_q, "byte count past message length")
  `I2C_MTS_ASSERT_NOW(a_length_sat, clk_i, rst_ni, 1'b1, 32'(length_q) <= i2c_mts_pkg::MAX_LEN, "length above limit")
  `I2C_MTS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, step_i && res.done_res, !active_q, "message active after done")

endmodule

`default_nettype wire

### rtl/core/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// sequences one i2c master message over a byte-level bus engine
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) takes command words:
//   tx buffer loads, message starts and byte-complete bus events
//   out channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
//   result word per command: bus engine action, received byte, status
//   path: an accepted word goes through the input register, one pass of
//   decision logic and the result register before its result is offered
//   throughput: one word per cycle, sustained with no stall downstream
//   stall: while the result register holds an untaken word and the input
//   register is full, in_ready_o drops; no word is lost or repeated
//   reset: rst_ni clears the message state and both pipeline valids;
//   the tx buffer holds no reset value and must be loaded before use
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire i2c_mts_pkg::in_word_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output i2c_mts_pkg::out_word_t      out_data_o
);

  logic                   in_valid_q;
  i2c_mts_pkg::in_word_t  in_q;
  logic                   out_valid_q;
  i2c_mts_pkg::out_word_t out_q;
  logic                   step;

  i2c_mts_pkg::out_word_t            res;
  i2c_mts_pkg::txbuf_wr_t            wr;
  logic [i2c_mts_pkg::BUF_AW-1:0]    rd_addr;
  logic [7:0]                        rd_data;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  i2c_mts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .rd_data_i (rd_data),
    .res_o     (res),
    .wr_o      (wr),
    .rd_addr_o (rd_addr)
  );

  i2c_mts_txbuf #(
    .WIDTH (8),
    .DEPTH (i2c_mts_pkg::BUF_DEPTH)
  ) u_txbuf (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `I2C_MTS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_valid_q && !in_ready_o, out_valid_q && !out_ready_i, "input stalled without output stall")
  `I2C_MTS_ASSERT_NEXT(a_step_result, clk_i, rst_ni, step, out_valid_q, "no result after step")
  `I2C_MTS_ASSERT_NOW(a_rx_read_only, clk_i, rst_ni, out_valid_q && out_q.rx_valid, out_q.read_mode, "received byte on write message")

endmodule

`default_nettype wire
